>>> src/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types and constants for the query parameter extractor.
// ----------------------------------------------------------------------------
package qpe_pkg;

	// Character codes
	localparam logic [7:0] CH_AMP = 8'h26; // '&'
	localparam logic [7:0] CH_LF  = 8'h0A; // newline
	localparam logic [7:0] CH_CR  = 8'h0D; // carriage return
	localparam logic [7:0] CH_EQ  = 8'h3D; // '='

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_NAME_LOW  = 2'd0,
		REG_NAME_HIGH = 2'd1,
		REG_NAME_LEN  = 2'd2,
		REG_LIMIT     = 2'd3
	} qpe_reg_t;

	localparam logic [8:0] LIMIT_RESET = 9'd256;

	// Scan phase
	typedef enum logic [1:0] {
		PH_FIELD = 2'd0, // at a field start, comparing name bytes
		PH_SKIP  = 2'd1, // field does not match, wait for terminator
		PH_VALUE = 2'd2, // streaming the value
		PH_DONE  = 2'd3  // value ended, ignore rest of string
	} qpe_phase_t;

	// One result transaction
	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       found;
		logic       done_res;
	} qpe_res_t;

	localparam int RES_DEPTH = 4;

endpackage

>>> src/qpe_text_if.sv
// ----------------------------------------------------------------------------
// qpe_text_if
// Input byte stream channel: one text byte per transaction.
// ----------------------------------------------------------------------------
interface qpe_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> src/qpe_result_if.sv
// ----------------------------------------------------------------------------
// qpe_result_if
// Result channel: one value byte and/or closing flags per transaction.
// ----------------------------------------------------------------------------
interface qpe_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       byte_valid;
	logic       found;
	logic       done_res;

	modport source (output valid, output value_byte, output byte_valid, output found,
		output done_res, input ready);
	modport sink   (input valid, input value_byte, input byte_valid, input found,
		input done_res, output ready);
endinterface

>>> src/qpe_cfg_if.sv
// ----------------------------------------------------------------------------
// qpe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qpe_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/query_parameter_extractor.sv
// ----------------------------------------------------------------------------
// query_parameter_extractor
// Finds the first field "name=value" in a byte stream and streams its value.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                    | Transaction
//  text    | in  | text_byte, end_of_text                     | one string byte
//  result  | out | value_byte, byte_valid, found, done_res    | one result
//  cfg     | in  | index (0..3), data                         | one register write
//
// Each text byte is taken into an input register and resolved from there;
// one byte per cycle is sustained while the 4-entry result queue has room.
// A byte yields 0, 1 or 2 results; the input register advances only when the
// queue has room for two, so text.ready falls while result.ready stays low.
// Reset clears all scan state and the queue; registers reset to empty name
// and limit 256. cfg.ready is always high.
// ----------------------------------------------------------------------------
module query_parameter_extractor
	import qpe_pkg::*;
#(
	parameter int NAME_BYTES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	qpe_text_if.sink        text,
	qpe_result_if.source    result,
	qpe_cfg_if.sink         cfg
);

	localparam int PW = $clog2(RES_DEPTH);

	// ---------------- configuration registers ----------------
	logic [63:0] name_low_q, name_high_q;
	logic [4:0]  name_len_q;
	logic [8:0]  limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_len_q  <= '0;
			limit_q     <= LIMIT_RESET;
		end else if (cfg.valid) begin
			case (qpe_reg_t'(cfg.index))
				REG_NAME_LOW:  name_low_q  <= cfg.data;
				REG_NAME_HIGH: name_high_q <= cfg.data;
				REG_NAME_LEN:  name_len_q  <= cfg.data[4:0];
				REG_LIMIT:     limit_q     <= cfg.data[8:0];
				default:       ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       adv;       // stage 1 item resolved this cycle
	logic       out_fire;
	logic [PW:0] cnt_q;

	assign out_fire   = result.valid && result.ready;
	// room for two results after this cycle's read
	assign adv        = v_s1 && ((cnt_q - {{PW{1'b0}}, out_fire}) <= (PW+1)'(RES_DEPTH - 2));
	assign text.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			end_s1  <= text.end_of_text;
		end
	end

	// ---------------- scan state ----------------
	qpe_phase_t phase_q, phase_d;
	logic [4:0] mc_q, mc_d;        // name bytes matched
	logic [8:0] vc_q, vc_d;        // value bytes emitted
	logic       hr_q, hr_d;        // held carriage return
	logic       nf_q, nf_d;        // name found

	// scan logic
	logic [4:0]   len;
	logic [127:0] name_all;
	logic [7:0]   name_b;
	logic         hit, is_term;
	logic [8:0]   cap;
	logic [1:0]   c_n;             // candidate value bytes
	logic [7:0]   c0, c1;
	logic         e0, e1;
	logic [1:0]   nw;
	qpe_res_t     r0, r1;

	assign len      = (name_len_q > 5'(NAME_BYTES)) ? 5'(NAME_BYTES) : name_len_q;
	assign name_all = {name_high_q, name_low_q};
	assign name_b   = name_all[{mc_q[3:0], 3'b000} +: 8];
	assign is_term  = (byte_s1 == CH_AMP) || (byte_s1 == CH_LF);
	assign cap      = (limit_q == 9'd0) ? 9'd0 : limit_q - 9'd1;

	always_comb begin
		phase_d = phase_q;
		mc_d    = mc_q;
		vc_d    = vc_q;
		hr_d    = hr_q;
		nf_d    = nf_q;
		c_n     = 2'd0;
		c0      = 8'd0;
		c1      = 8'd0;
		hit     = 1'b0;

		case (phase_q)
			PH_FIELD: begin
				hit = (mc_q < len) ? (byte_s1 == name_b) : (byte_s1 == CH_EQ);
				if (hit) begin
					if (mc_q < len) begin
						mc_d = mc_q + 5'd1;
					end else begin
						nf_d    = 1'b1;
						phase_d = PH_VALUE;
						vc_d    = 9'd0;
						hr_d    = 1'b0;
					end
				end else if (is_term) begin
					mc_d = 5'd0;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (is_term) begin
					phase_d = PH_FIELD;
					mc_d    = 5'd0;
				end
			end
			PH_VALUE: begin
				hr_d = 1'b0;
				if (hr_q && byte_s1 == CH_LF) begin
					phase_d = PH_DONE;  // CR LF: drop the CR
				end else begin
					if (hr_q) begin
						c_n = 2'd1;
						c0  = CH_CR;
					end
					if (is_term) begin
						phase_d = PH_DONE;
					end else if (byte_s1 == CH_CR) begin
						hr_d = 1'b1;
					end else begin
						if (c_n == 2'd0) c0 = byte_s1;
						else             c1 = byte_s1;
						c_n = c_n + 2'd1;
					end
				end
				// string ends on a held CR: emit it
				if (end_s1 && phase_d == PH_VALUE && hr_d) begin
					hr_d = 1'b0;
					if (c_n == 2'd0) c0 = CH_CR;
					else             c1 = CH_CR;
					c_n = c_n + 2'd1;
				end
			end
			default: ;
		endcase

		// length cap; a refused byte refuses everything after it
		e0 = (c_n != 2'd0) && (vc_q < cap);
		e1 = e0 && (c_n == 2'd2) && ((vc_q + 9'd1) < cap);
		vc_d = vc_d + {8'd0, e0} + {8'd0, e1};

		r0 = '{value_byte: e0 ? c0 : 8'd0, byte_valid: e0, found: 1'b0, done_res: 1'b0};
		r1 = '{value_byte: c1, byte_valid: 1'b1, found: 1'b0, done_res: 1'b0};
		nw = {1'b0, e0} + {1'b0, e1};

		if (end_s1) begin
			if (e1) begin
				r1.found    = nf_d;
				r1.done_res = 1'b1;
			end else begin
				r0.found    = nf_d;
				r0.done_res = 1'b1;
				nw          = e0 ? 2'd1 : 2'd1;
			end
			phase_d = PH_FIELD;
			mc_d    = 5'd0;
			vc_d    = 9'd0;
			hr_d    = 1'b0;
			nf_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIELD;
			mc_q    <= '0;
			vc_q    <= '0;
			hr_q    <= 1'b0;
			nf_q    <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			mc_q    <= mc_d;
			vc_q    <= vc_d;
			hr_q    <= hr_d;
			nf_q    <= nf_d;
		end
	end

	// ---------------- result queue ----------------
	qpe_res_t        res_mem [RES_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [1:0]      nw_eff;

	assign nw_eff = adv ? nw : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(nw_eff);
			rp_q  <= rp_q + PW'(out_fire);
			cnt_q <= cnt_q + (PW+1)'(nw_eff) - (PW+1)'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (nw_eff != 2'd0) res_mem[wp_q] <= r0;
		if (nw_eff == 2'd2) res_mem[wp_q + PW'(1)] <= r1;
	end

	assign result.valid      = (cnt_q != '0);
	assign result.value_byte = res_mem[rp_q].value_byte;
	assign result.byte_valid = res_mem[rp_q].byte_valid;
	assign result.found      = res_mem[rp_q].found;
	assign result.done_res   = res_mem[rp_q].done_res;

endmodule

>>> dv/qpe_checker.sv
// ----------------------------------------------------------------------------
// qpe_checker
// Watches the text, result and register channels of the query parameter
// extractor. It tracks the register writes, predicts the results of every
// accepted text byte and compares each result transaction against them.
// ----------------------------------------------------------------------------
module qpe_checker
	import qpe_pkg::*;
#(
	parameter int NAME_BYTES = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	qpe_text_if   text,
	qpe_result_if result,
	qpe_cfg_if    cfg,
	output int    errors,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copy
	logic [63:0] name_lo;
	logic [63:0] name_hi;
	logic [4:0]  name_len;
	logic [8:0]  limit;

	// scan state
	qpe_phase_t  scan;
	logic [4:0]  name_hits;
	logic [8:0]  emitted;
	logic        cr_held;
	logic        name_seen;

	qpe_res_t    expected_results[$];
	qpe_res_t    step_out[2];
	int          step_cnt;
	int          fails;
	qpe_res_t    got;
	qpe_res_t    want;

	function automatic logic [7:0] name_byte(input int i);
		if (i < 8)
			return name_lo[8*i +: 8];
		return name_hi[8*(i-8) +: 8];
	endfunction

	function automatic logic is_term(input logic [7:0] b);
		return b == CH_AMP || b == CH_LF;
	endfunction

	// at most limit-1 value bytes, at most two per text byte
	task automatic emit_value(input logic [7:0] b);
		logic [8:0] cap;
		cap = (limit == 9'd0) ? 9'd0 : limit - 9'd1;
		if (emitted < cap && step_cnt < 2) begin
			step_out[step_cnt] = {b, 1'b1, 1'b0, 1'b0};
			step_cnt++;
			emitted++;
		end
	endtask

	task automatic predict_text(input logic [7:0] b, input logic last);
		logic [4:0] len;
		logic       hit;
		len = (name_len > NAME_BYTES) ? 5'(NAME_BYTES) : name_len;
		step_cnt = 0;
		case (scan)
			PH_FIELD: begin
				hit = (name_hits < len) ? (b == name_byte(name_hits)) : (b == CH_EQ);
				if (hit) begin
					if (name_hits < len) begin
						name_hits++;
					end else begin
						name_seen = 1'b1;
						scan      = PH_VALUE;
						emitted   = '0;
						cr_held   = 1'b0;
					end
				end else if (is_term(b)) begin
					name_hits = '0;
				end else begin
					scan = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (is_term(b)) begin
					scan      = PH_FIELD;
					name_hits = '0;
				end
			end
			PH_VALUE: begin
				// a held CR is dropped only in front of a newline
				if (cr_held && b == CH_LF) begin
					cr_held = 1'b0;
					scan    = PH_DONE;
				end else begin
					if (cr_held) begin
						cr_held = 1'b0;
						emit_value(CH_CR);
					end
					if (is_term(b))
						scan = PH_DONE;
					else if (b == CH_CR)
						cr_held = 1'b1;
					else
						emit_value(b);
				end
			end
			default: ;
		endcase

		if (last && scan == PH_VALUE && cr_held) begin
			cr_held = 1'b0;
			emit_value(CH_CR);
		end

		if (last) begin
			if (step_cnt == 0) begin
				step_out[0] = '0;
				step_cnt    = 1;
			end
			step_out[step_cnt-1].found    = name_seen;
			step_out[step_cnt-1].done_res = 1'b1;
		end
		for (int k = 0; k < step_cnt; k++)
			expected_results.push_back(step_out[k]);
		if (last) begin
			scan      = PH_FIELD;
			name_hits = '0;
			emitted   = '0;
			cr_held   = 1'b0;
			name_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_lo   = '0;
			name_hi   = '0;
			name_len  = '0;
			limit     = LIMIT_RESET;
			scan      = PH_FIELD;
			name_hits = '0;
			emitted   = '0;
			cr_held   = 1'b0;
			name_seen = 1'b0;
			fails     = 0;
			expected_results.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (qpe_reg_t'(cfg.index))
					REG_NAME_LOW:  name_lo  = cfg.data;
					REG_NAME_HIGH: name_hi  = cfg.data;
					REG_NAME_LEN:  name_len = cfg.data[4:0];
					REG_LIMIT:     limit    = cfg.data[8:0];
					default: ;
				endcase
			end

			if (text.valid && text.ready)
				predict_text(text.text_byte, text.end_of_text);

			if (result.valid && result.ready) begin
				got = {result.value_byte, result.byte_valid, result.found, result.done_res};
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: value_byte %02h byte_valid %0b found %0b done_res %0b",
						got.value_byte, got.byte_valid, got.found, got.done_res);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.value_byte !== want.value_byte) begin
						$error("value_byte: expected %02h, got %02h", want.value_byte, got.value_byte);
						fails++;
					end
					if (got.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
						fails++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, got.found);
						fails++;
					end
					if (got.done_res !== want.done_res) begin
						$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
						fails++;
					end
				end
			end

			errors      <= fails;
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> dv/tb_query_parameter_extractor.sv
// ----------------------------------------------------------------------------
// tb_query_parameter_extractor
// Drives query strings into the extractor under several parameter names and
// value limits, with random idling on both channels, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_query_parameter_extractor
	import qpe_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_BYTES  = 16;
	localparam int LONG_HOLD   = 200;  // receiver hold-off that backs up the queue
	localparam int STALL_LIMIT = 3000; // cycles without any transaction
	localparam int SETTLE      = 12;   // input register + result queue drain
	localparam int MIX_ITEMS   = 4;    // text bytes per idling mode
	localparam int LONG_VALUE  = 258;  // runs past the 255-byte cap of limit 256

	typedef logic [7:0] text_t[$];

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// stimulus knobs, written only by the main sequence
	int send_idle_pct  = 0;
	int take_stall_pct = 0;
	int holds_asked    = 0;
	// written only by the receiver
	int holds_done     = 0;

	int items_sent = 0;
	int quiet_cycles = 0;
	int errors;
	int outstanding;

	// testbench view of the name currently loaded
	logic [7:0] name_now[NAME_BYTES];
	int         name_len_eff = 0;

	qpe_text_if   text ();
	qpe_result_if result ();
	qpe_cfg_if    cfg ();

	query_parameter_extractor #(
		.NAME_BYTES(NAME_BYTES)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.result (result),
		.cfg    (cfg)
	);

	qpe_checker #(
		.NAME_BYTES(NAME_BYTES)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.result      (result),
		.cfg         (cfg),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Result side: random stalls, plus a long hold-off whenever the main
	// sequence asks for one. The hold is counted here so the sender keeps
	// offering bytes until the block backs up and drops text.ready.
	// ------------------------------------------------------------------
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				result.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end
			result.ready <= ($urandom_range(99) >= take_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any cycle with a transaction on some channel resets it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (text.valid && text.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Register writes. valid stays up across a batch and is lowered once.
	// ------------------------------------------------------------------
	task automatic write_reg(input qpe_reg_t idx, input logic [63:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// len/limit go out with random upper bits; the block keeps the low ones
	task automatic load_config(input logic [4:0] len, input logic [8:0] lim,
			input logic [127:0] name_bits);
		logic [63:0] junk;
		for (int k = 0; k < NAME_BYTES; k++)
			name_now[k] = name_bits[8*k +: 8];
		name_len_eff = (len > NAME_BYTES) ? NAME_BYTES : len;
		write_reg(REG_NAME_LOW,  name_bits[63:0]);
		write_reg(REG_NAME_HIGH, name_bits[127:64]);
		junk = {$urandom, $urandom};
		write_reg(REG_NAME_LEN,  {junk[63:5], len});
		junk = {$urandom, $urandom};
		write_reg(REG_LIMIT,     {junk[63:9], lim});
		cfg.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Text side. valid is held high between back-to-back bytes and only
	// dropped for an idle cycle, so it never toggles within one step.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid       <= 1'b1;
		text.text_byte   <= b;
		text.end_of_text <= last;
		do @(posedge clk); while (!text.ready);
		items_sent++;
	endtask

	task automatic send_text(input text_t s);
		for (int i = 0; i < s.size(); i++)
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Let every expected result arrive, then wait out a byte that may still
	// sit in the input register without producing anything.
	task automatic idle_drain();
		text.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// String generators
	// ------------------------------------------------------------------
	function automatic logic [7:0] value_char();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'h61 + 8'($urandom_range(25));  // lower-case letter
		if (r < 70)
			return 8'h30 + 8'($urandom_range(9));   // digit
		if (r < 80)
			return CH_CR;
		if (r < 85)
			return CH_EQ;
		return 8'($urandom_range(255));
	endfunction

	// Mostly well-formed "a=b&c=d" strings where the wanted field shows up
	// often, with near misses, CRLF separators and occasional truncation.
	function automatic text_t make_query();
		text_t s;
		int    fields;
		int    cut;
		int    vlen;
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if (f != 0) begin
				case ($urandom_range(2))
					0: s.push_back(CH_AMP);
					1: s.push_back(CH_LF);
					default: begin
						s.push_back(CH_CR);
						s.push_back(CH_LF);
					end
				endcase
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					for (int k = 0; k < name_len_eff; k++)
						s.push_back(name_now[k]);
					s.push_back(CH_EQ);
				end
				5, 6: begin
					// name prefix then a stray byte
					cut = (name_len_eff == 0) ? 0 : $urandom_range(name_len_eff - 1);
					for (int k = 0; k < cut; k++)
						s.push_back(name_now[k]);
					s.push_back(8'h61 + 8'($urandom_range(25)));
					if ($urandom_range(1))
						s.push_back(CH_EQ);
				end
				7: ;
				default: begin
					s.push_back(8'h61 + 8'($urandom_range(25)));
					s.push_back(CH_EQ);
				end
			endcase
			vlen = $urandom_range(0, 6);
			for (int k = 0; k < vlen; k++)
				s.push_back(value_char());
			if ($urandom_range(3) == 0)
				s.push_back(CH_CR);
		end
		// broken sequence: string cut off early
		if ($urandom_range(4) == 0)
			while (s.size() > 1 && $urandom_range(3) != 0)
				void'(s.pop_back());
		if (s.size() == 0)
			s.push_back(value_char());
		return s;
	endfunction

	function automatic text_t make_noise();
		text_t s;
		int    n;
		n = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(5))
				0: s.push_back(CH_AMP);
				1: s.push_back(CH_EQ);
				2: s.push_back(name_now[$urandom_range(NAME_BYTES - 1)]);
				default: s.push_back(8'($urandom_range(255)));
			endcase
		end
		return s;
	endfunction

	task automatic send_mix(input int goal, input int sidle, input int tstall);
		int stop_at;
		send_idle_pct  = sidle;
		take_stall_pct = tstall;
		stop_at        = items_sent + goal;
		while (items_sent < stop_at) begin
			if ($urandom_range(9) < 8)
				send_text(make_query());
			else
				send_text(make_noise());
		end
	endtask

	// one register setting, run through every idling mode
	task automatic random_phase(input logic [4:0] len, input logic [8:0] lim,
			input logic squeeze);
		load_config(len, lim, {$urandom, $urandom, $urandom, $urandom});
		if (squeeze)
			holds_asked++;
		send_mix(MIX_ITEMS, 0, 0);
		send_mix(MIX_ITEMS, 68, 0);
		send_mix(MIX_ITEMS, 0, 68);
		send_mix(MIX_ITEMS, 23, 23);
		idle_drain();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		text_t s;
		text.valid       = 1'b0;
		text.text_byte   = '0;
		text.end_of_text = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_NAME_LOW;
		cfg.data         = '0;
		for (int k = 0; k < NAME_BYTES; k++)
			name_now[k] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// -- directed, reset registers: empty name, limit 256 --
		// empty name matches '='; held CR flushed by '&' which ends the value
		s = '{CH_EQ, "a", CH_CR, CH_AMP, "z"};
		send_text(s);
		// zero byte is plain data
		s = '{8'h00};
		send_text(s);
		// last byte's value byte rides on the closing transaction
		s = '{CH_EQ, 8'hFF};
		send_text(s);
		// CR still held at end of string goes out
		s = '{CH_EQ, "q", CH_CR};
		send_text(s);
		idle_drain();

		// -- directed: name holding '&', limit 3 (two value bytes) --
		load_config(5'd2, 9'd3, {96'h0, 16'h0000, CH_AMP, 8'h6B});
		// CR before CR is emitted, CR before newline dropped
		s = '{8'h6B, CH_AMP, CH_EQ, CH_CR, CH_CR, CH_LF};
		send_text(s);
		// value capped at limit minus one
		s = '{8'h6B, CH_AMP, CH_EQ, "a", "b", "c", "d"};
		send_text(s);
		idle_drain();

		// -- random part over register extremes --
		random_phase(5'd3,  9'd256, 1'b1);
		random_phase(5'd16, 9'd1,   1'b0);
		random_phase(5'd31, 9'd0,   1'b0);  // length over NAME_BYTES, zero limit
		random_phase(5'd8,  9'd2,   1'b1);
		random_phase(5'd1,  9'd511, 1'b0);
		random_phase(5'd0,  9'd256, 1'b0);

		// one value long enough to hit the 255-byte cap
		s = '{CH_EQ};
		for (int k = 0; k < LONG_VALUE; k++)
			s.push_back(8'h61 + 8'($urandom_range(25)));
		send_text(s);
		idle_drain();

		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
